@@ src/bwm_pkg.sv @@
// ----------------------------------------------------------------------------
// bwm_pkg
// Shared types and constants for the bridge window mapper.
// ----------------------------------------------------------------------------
package bwm_pkg;

  localparam int AlignBits     = 16;
  localparam int MaxWindowLog2 = 27;
  localparam int SizeBits      = 29;
  localparam int OffsetBits    = 28;

  localparam logic [31:0] MaxWindow = 32'(1) << MaxWindowLog2;
  localparam logic [31:0] LowMask   = 32'h0000_ffff;

  localparam logic [1:0] StatusHit     = 2'd0;
  localparam logic [1:0] StatusNew     = 2'd1;
  localparam logic [1:0] StatusInvalid = 2'd2;

  typedef struct packed {
    logic [1:0]            status;
    logic [OffsetBits-1:0] window_offset;
    logic [31:0]           base_word;
    logic [31:0]           mask_word;
    logic                  load_window;
    logic [31:0]           new_base;
    logic [SizeBits-1:0]   new_size;
  } calc_out_t;

endpackage

@@ src/bwm_calc.sv @@
// ----------------------------------------------------------------------------
// bwm_calc
// Window lookup: hit test, length check and new window sizing.
// ----------------------------------------------------------------------------
module bwm_calc (
  input  logic [31:0]                 request_address,
  input  logic [31:0]                 request_length,
  input  logic [31:0]                 window_base,
  input  logic [bwm_pkg::SizeBits-1:0] window_size,
  output bwm_pkg::calc_out_t          result
);

  logic [32:0] span_end;
  logic [32:0] win_end;
  logic        hit;
  logic        too_long;
  logic [31:0] aligned;
  logic [32:0] need;
  logic [31:0] need_m1;
  logic [31:0] smear;
  logic [31:0] size_m1;
  logic [31:0] size;
  logic [31:0] diff;

  always_comb begin
    span_end = {1'b0, request_address} + {1'b0, request_length};
    win_end  = {1'b0, window_base} + 33'(window_size);
    hit      = (request_address >= window_base) && (span_end <= win_end);
    too_long = request_length > bwm_pkg::MaxWindow;
    aligned  = request_address & ~bwm_pkg::LowMask;
    diff     = request_address - window_base;

    // The span measured from the aligned base is never shorter than the length.
    need    = {1'b0, request_length} + 33'(request_address[bwm_pkg::AlignBits-1:0]);
    need_m1 = (need == 33'd0) ? 32'd0 : (need[31:0] - 32'd1);

    // Fill every bit below the leading one to round up to a power of two.
    smear = need_m1;
    smear = smear | (smear >> 1);
    smear = smear | (smear >> 2);
    smear = smear | (smear >> 4);
    smear = smear | (smear >> 8);
    smear = smear | (smear >> 16);
    size_m1 = smear | bwm_pkg::LowMask;
    size    = size_m1 + 32'd1;

    result = '0;
    if (hit) begin
      result.status        = bwm_pkg::StatusHit;
      result.window_offset = diff[bwm_pkg::OffsetBits-1:0];
    end else if (too_long) begin
      result.status = bwm_pkg::StatusInvalid;
    end else begin
      result.status        = bwm_pkg::StatusNew;
      result.window_offset = bwm_pkg::OffsetBits'(request_address[bwm_pkg::AlignBits-1:0]);
      result.base_word     = aligned;
      result.mask_word     = ~size_m1 | (size_m1 >> bwm_pkg::AlignBits);
      result.load_window   = 1'b1;
      result.new_base      = aligned;
      result.new_size      = size[bwm_pkg::SizeBits-1:0];
    end
  end

endmodule

@@ src/bridge_window_mapper_core.sv @@
// ----------------------------------------------------------------------------
// bridge_window_mapper_core
// Maps a physical byte span onto a single sliding bus window.
// ----------------------------------------------------------------------------
// Takes one request per clock unless stalled and returns one result per
// request: the request lands in an input register, the lookup runs in one
// combinational pass, and the answer is caught in the result register while
// the window base and size are updated at the same edge, so the next request
// already sees the new window. A stalled result holds the input register;
// the input side stalls only while both registers are full.
module bridge_window_mapper_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_request_address,
  input  logic [31:0] in_request_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [27:0] out_window_offset,
  output logic [31:0] out_base_word,
  output logic [31:0] out_mask_word
);

  logic                          req_valid_r;
  logic [31:0]                   req_addr_r;
  logic [31:0]                   req_len_r;
  logic                          out_valid_r;
  logic [1:0]                    status_r;
  logic [bwm_pkg::OffsetBits-1:0] offset_r;
  logic [31:0]                   base_word_r;
  logic [31:0]                   mask_word_r;
  logic [31:0]                   window_base_r;
  logic [bwm_pkg::SizeBits-1:0]  window_size_r;
  logic                          advance;
  logic                          in_xfer;
  bwm_pkg::calc_out_t            calc;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = req_valid_r && !advance;
  assign in_xfer  = in_valid && !in_stall;

  bwm_calc u_calc (
    .request_address (req_addr_r),
    .request_length  (req_len_r),
    .window_base     (window_base_r),
    .window_size     (window_size_r),
    .result          (calc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r   <= 1'b0;
      out_valid_r   <= 1'b0;
      window_base_r <= '0;
      window_size_r <= '0;
    end else begin
      if (in_xfer) begin
        req_valid_r <= 1'b1;
      end else if (advance) begin
        req_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= req_valid_r;
        if (req_valid_r && calc.load_window) begin
          window_base_r <= calc.new_base;
          window_size_r <= calc.new_size;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_addr_r <= in_request_address;
      req_len_r  <= in_request_length;
    end
    if (advance && req_valid_r) begin
      status_r    <= calc.status;
      offset_r    <= calc.window_offset;
      base_word_r <= calc.base_word;
      mask_word_r <= calc.mask_word;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_window_offset = offset_r;
  assign out_base_word     = base_word_r;
  assign out_mask_word     = mask_word_r;

endmodule

@@ src/bwm_checker.sv @@
// ----------------------------------------------------------------------------
// bwm_checker
// Port-level checks on the result channel of the window mapper.
// ----------------------------------------------------------------------------
module bwm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [27:0] out_window_offset,
  input logic [31:0] out_base_word,
  input logic [31:0] out_mask_word
);

  // A stalled result must stay in place until its transfer.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_window_offset) && $stable(out_base_word) && $stable(out_mask_word))
    else $error("stalled result changed");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

  a_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bwm_pkg::StatusInvalid |->
      out_window_offset == '0 && out_base_word == '0 && out_mask_word == '0)
    else $error("invalid result carries data");

  a_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bwm_pkg::StatusHit |->
      out_base_word == '0 && out_mask_word == '0)
    else $error("hit result carries register words");

  // A new window is 64 KiB aligned, so the offset fits in the low half. The
  // size mask is at least 16 bits wide, so the low half of the mask word
  // repeats the upper half of the mask and the upper half holds its inverse.
  a_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bwm_pkg::StatusNew |->
      out_base_word[15:0] == 16'd0 && out_window_offset[27:16] == 12'd0 &&
      out_mask_word[31:16] == ~out_mask_word[15:0])
    else $error("new window words malformed");

endmodule

bind bridge_window_mapper_core bwm_checker u_bwm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_window_offset (out_window_offset),
  .out_base_word     (out_base_word),
  .out_mask_word     (out_mask_word)
);

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bridge_window_mapper_core. A behavioral model of
// the sliding window predicts every result at the moment a request transfer
// happens. A checker process compares each result transfer against the
// oldest prediction. Directed tests cover the reset window, window sizing,
// length limits and address extremes. A long random phase then mixes hits,
// new windows, boundary straddles and invalid lengths. Both channels idle
// and stall at random throughout the run.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [1:0]                     status;
    logic [bwm_pkg::OffsetBits-1:0] window_offset;
    logic [31:0]                    base_word;
    logic [31:0]                    mask_word;
  } map_result_t;

  typedef enum logic [1:0] {
    StallNone,
    StallLight,
    StallHeavy,
    StallPeriodic
  } stall_mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_request_address;
  logic [31:0] in_request_length;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [27:0] out_window_offset;
  logic [31:0] out_base_word;
  logic [31:0] out_mask_word;

  // Window held by the predictor; it follows the block's window in request order.
  logic [31:0]                  win_base;
  logic [bwm_pkg::SizeBits-1:0] win_size;

  map_result_t pending_results[$];

  int          failures;
  int          results_checked;
  int          hit_count;
  int          open_count;
  int          invalid_count;
  int          burst_left;
  int          stall_left;
  stall_mode_t stall_mode;

  bridge_window_mapper_core uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_request_address (in_request_address),
    .in_request_length  (in_request_length),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_window_offset  (out_window_offset),
    .out_base_word      (out_base_word),
    .out_mask_word      (out_mask_word)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Works out the result of one request and moves the window when a new one opens.
  function automatic map_result_t map_request(input logic [31:0] addr,
                                              input logic [31:0] len);
    logic [63:0] span_end;
    logic [63:0] win_end;
    logic [63:0] need;
    logic [63:0] size;
    logic [63:0] m;
    logic [31:0] aligned;
    map_result_t r;
    span_end = 64'(addr) + 64'(len);
    win_end  = 64'(win_base) + 64'(win_size);
    aligned  = addr & ~bwm_pkg::LowMask;
    r = '0;
    if (addr >= win_base && span_end <= win_end) begin
      r.status        = bwm_pkg::StatusHit;
      r.window_offset = bwm_pkg::OffsetBits'(addr - win_base);
      hit_count++;
    end else if (64'(len) > (64'd1 << bwm_pkg::MaxWindowLog2)) begin
      r.status = bwm_pkg::StatusInvalid;
      invalid_count++;
    end else begin
      need = span_end - 64'(aligned);
      if (need < 64'(len)) begin
        need = 64'(len);
      end
      size = 64'd1 << bwm_pkg::AlignBits;
      while (size < need) begin
        size = size << 1;
      end
      m = size - 64'd1;
      r.status        = bwm_pkg::StatusNew;
      r.window_offset = bwm_pkg::OffsetBits'(addr & bwm_pkg::LowMask);
      r.base_word     = aligned;
      r.mask_word     = ~m[31:0] | m[47:16];
      win_base = aligned;
      win_size = size[bwm_pkg::SizeBits-1:0];
      open_count++;
    end
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_request(input logic [31:0] addr, input logic [31:0] len);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid           <= 1'b1;
    in_request_address <= addr;
    in_request_length  <= len;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    pending_results.push_back(map_request(addr, len));
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic test_reset_window();
    send_request(32'h0000_0000, 32'd0);
    send_request(32'h0000_0000, 32'd1);
    // A zero-length request right at the window end still hits.
    send_request(32'h0001_0000, 32'd0);
    send_request(32'h0001_0001, 32'd0);
    wait_for_results();
  endtask

  task automatic test_window_sizing();
    send_request(32'h0001_0000, 32'h0001_0001);
    send_request(32'h1234_5678, 32'h0001_0000);
    send_request(32'h1234_5678, 32'h0000_8000);
    send_request(32'h0abc_ffff, 32'd2);
    send_request(32'h4000_0000, 32'h0001_2345);
    wait_for_results();
  endtask

  task automatic test_length_limits();
    send_request(32'h8000_0000, bwm_pkg::MaxWindow);
    send_request(32'h9000_0000, bwm_pkg::MaxWindow + 32'd1);
    send_request(32'h9000_0000, 32'hffff_ffff);
    send_request(32'h2000_ffff, bwm_pkg::MaxWindow);
    // An offset equal to a 2^28 window size wraps to zero in 28 bits.
    send_request(32'h3000_0000, 32'd0);
    wait_for_results();
  endtask

  task automatic test_address_extremes();
    send_request(32'hffff_ffff, bwm_pkg::MaxWindow);
    // Spans past 4 GiB must compare without wrapping.
    send_request(32'hffff_ff00, 32'h0000_1000);
    // A hit wins over the length limit.
    send_request(32'hffff_0001, bwm_pkg::MaxWindow + 32'd1);
    send_request(32'hffff_ffff, 32'd0);
    send_request(32'hffff_ffff, 32'd1);
    send_request(32'hffff_ffff, 32'hffff_ffff);
    send_request(32'h0000_0000, 32'hffff_0000);
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int count);
    int          pick;
    int          k;
    int unsigned off;
    logic [31:0] addr;
    logic [31:0] len;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        off  = $urandom_range(0, win_size);
        addr = win_base + off;
        len  = $urandom_range(0, win_size - off);
      end else if (pick < 65) begin
        k    = $urandom_range(0, 28);
        addr = $urandom;
        len  = $urandom & ((32'd1 << k) - 32'd1);
      end else if (pick < 75) begin
        // Straddle the current window end from just inside.
        addr = win_base + win_size - $urandom_range(0, 32);
        len  = $urandom_range(0, 64);
      end else if (pick < 85) begin
        addr = $urandom;
        len  = $urandom_range(bwm_pkg::MaxWindow + 32'd1, 32'hffff_ffff);
      end else begin
        addr = $urandom;
        len  = $urandom;
      end
      send_request(addr, len);
      if (i % 200 == 199) begin
        wait_for_results();
      end
    end
    wait_for_results();
  endtask

  // The receiver switches at random between stall patterns.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 80);
    end
    stall_left--;
    case (stall_mode)
      StallNone:  out_stall <= 1'b0;
      StallLight: out_stall <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall <= ($urandom_range(0, 3) != 0);
      default:    out_stall <= (stall_left % 5 < 2);
    endcase
  end

  always @(posedge clk) begin : result_check
    map_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no request outstanding");
        failures++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          failures++;
        end
        if (out_window_offset !== want.window_offset) begin
          $error("window_offset: expected %h, got %h", want.window_offset,
                 out_window_offset);
          failures++;
        end
        if (out_base_word !== want.base_word) begin
          $error("base_word: expected %h, got %h", want.base_word, out_base_word);
          failures++;
        end
        if (out_mask_word !== want.mask_word) begin
          $error("mask_word: expected %h, got %h", want.mask_word, out_mask_word);
          failures++;
        end
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_request_address = '0;
    in_request_length  = '0;
    out_stall          = 1'b0;
    win_base           = '0;
    win_size           = '0;
    failures           = 0;
    results_checked    = 0;
    hit_count          = 0;
    open_count         = 0;
    invalid_count      = 0;
    burst_left         = 0;
    stall_left         = 0;
    stall_mode         = StallNone;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_window();
    test_window_sizing();
    test_length_limits();
    test_address_extremes();
    test_random_traffic(800);

    in_valid <= 1'b0;
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      failures++;
    end
    $display("Sent %0d requests: %0d window hits, %0d new windows, %0d invalid lengths.",
             hit_count + open_count + invalid_count, hit_count, open_count, invalid_count);
    $display("Checked %0d results with %0d field mismatches or protocol faults.",
             results_checked, failures);
    if (failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/bwm_pkg.sv
src/bwm_calc.sv
src/bridge_window_mapper_core.sv
src/bwm_checker.sv
dv/testbench.sv
